### rtl/fitzhugh_nagumo_derivative_unit_assert.svh
// Assertion macros shared by the derivative unit RTL.
`ifndef FITZHUGH_NAGUMO_DERIVATIVE_UNIT_ASSERT_SVH
`define FITZHUGH_NAGUMO_DERIVATIVE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define FND_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FND_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FND_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FND_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/fnd_pkg.sv
// Shared types, constants and fixed-point helpers for the derivative unit.
`timescale 1ns / 1ps

package fnd_pkg;

    localparam int SINE_W = 18;
    localparam int ROM_W  = 17;

    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] Q16_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] Q16_MIN     = -64'sd2147483648;
    localparam logic signed [63:0] ROUND_HALF  = 64'sd32768;

    typedef logic signed [31:0]       q16_t;
    typedef logic signed [63:0]       prod_t;
    typedef logic signed [SINE_W-1:0] sine_t;

    typedef struct packed {
        logic ovf;
        q16_t val;
    } sat_res_t;

    typedef enum logic [2:0] {
        REG_CUBIC_GAIN        = 3'd0,
        REG_RECOVERY_COUPLING = 3'd1,
        REG_THRESHOLD_AMP     = 3'd2,
        REG_WAVE_FREQUENCY    = 3'd3,
        REG_UPPER_ROOT        = 3'd4,
        REG_RECOVERY_RATE     = 3'd5,
        REG_RECOVERY_DECAY    = 3'd6,
        REG_SLOW_WAVE_MODE    = 3'd7
    } cfg_reg_t;

    // per-stage load enables for the sine pipeline
    typedef struct packed {
        logic rom_en;
        logic addr_en;
        logic step_en;
    } sine_ctl_t;

    function automatic sat_res_t sat32(input prod_t v);
        sat_res_t res;
        res.ovf = 1'b0;
        res.val = v[31:0];
        if (v > Q16_MAX) begin
            res.ovf = 1'b1;
            res.val = Q16_MAX[31:0];
        end else if (v < Q16_MIN) begin
            res.ovf = 1'b1;
            res.val = Q16_MIN[31:0];
        end
        return res;
    endfunction

    // Q32.32 product back to Q16.16: round half up, floor shift, saturate
    function automatic sat_res_t qround(input prod_t v);
        prod_t r;
        r = (v + ROUND_HALF) >>> 16;
        return sat32(r);
    endfunction

endpackage

### rtl/fitzhugh_nagumo_derivative_unit.sv
// FitzHugh-Nagumo derivative unit. Takes one cell (time, u, r, stimulus) per
// transfer and returns du and dr in signed Q16.16 with a per-result clip flag.
// Throughput is one item per clock while the output is not stalled. The
// latency is set by the beta path: time product, sine table step, table
// address, table read, amplitude product, beta rounding, u - beta, then the
// two dependent cubic products, each followed by its own rounding stage, and
// the final sum in the output register. A full stage holds when the stage
// ahead is full and stalled, so bubbles collapse and input keeps flowing
// while a result waits. The sine table is a constant quarter-wave ROM of
// SINE_TABLE_DEPTH+1 entries built at elaboration; there is no clearing pass
// after reset. Configuration writes are always accepted.
`timescale 1ns / 1ps
`include "fitzhugh_nagumo_derivative_unit_assert.svh"

module fitzhugh_nagumo_derivative_unit
    import fnd_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sim_time,
    input  q16_t        s_excitation,
    input  q16_t        s_recovery,
    input  q16_t        s_stimulus,

    output logic        m_valid,
    input  logic        m_ready,
    output q16_t        m_excitation_rate,
    output q16_t        m_recovery_rate_out,
    output logic        m_saturated
);

    localparam int STAGES = 11;

    typedef struct packed {
        logic        sat;
        logic [31:0] phase;
        q16_t        u;
        q16_t        stim;
        q16_t        d2;
        q16_t        q;
        q16_t        au;
        q16_t        e;
        q16_t        dr;
        q16_t        beta;
        q16_t        d1;
        q16_t        p;
        prod_t       prod0;
        prod_t       prod1;
        prod_t       prod2;
    } stage_t;

    // configuration registers
    q16_t        cubic_gain_reg;
    q16_t        recovery_coupling_reg;
    q16_t        amp_reg;
    logic [30:0] freq_reg;
    q16_t        upper_root_reg;
    q16_t        recovery_rate_reg;
    q16_t        recovery_decay_reg;
    logic        slow_wave_mode_reg;

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] stage_en;
    logic            out_en;
    stage_t          stg_reg  [STAGES:1];
    stage_t          stg_next [STAGES:1];

    logic            m_valid_reg;
    q16_t            m_du_reg, m_du_next;
    q16_t            m_dr_reg;
    logic            m_sat_reg, m_sat_next;

    sine_t           sine_val;
    sine_ctl_t       sine_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cubic_gain_reg        <= '0;
            recovery_coupling_reg <= '0;
            amp_reg               <= '0;
            freq_reg              <= '0;
            upper_root_reg        <= '0;
            recovery_rate_reg     <= '0;
            recovery_decay_reg    <= '0;
            slow_wave_mode_reg    <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_CUBIC_GAIN:        cubic_gain_reg        <= cfg_data;
                REG_RECOVERY_COUPLING: recovery_coupling_reg <= cfg_data;
                REG_THRESHOLD_AMP:     amp_reg               <= cfg_data;
                REG_WAVE_FREQUENCY:    freq_reg              <= cfg_data[30:0];
                REG_UPPER_ROOT:        upper_root_reg        <= cfg_data;
                REG_RECOVERY_RATE:     recovery_rate_reg     <= cfg_data;
                REG_RECOVERY_DECAY:    recovery_decay_reg    <= cfg_data;
                REG_SLOW_WAVE_MODE:    slow_wave_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the stage ahead moves
    always_comb begin
        out_en           = !m_valid_reg || m_ready;
        stage_en[STAGES] = !valid_reg[STAGES] || out_en;
        for (int k = STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready = stage_en[1];

    assign sine_ctl = '{rom_en: stage_en[4], addr_en: stage_en[3], step_en: stage_en[2]};

    fnd_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .aclk  (aclk),
        .ctl   (sine_ctl),
        .phase (stg_reg[1].phase),
        .sine  (sine_val)
    );

    always_comb begin
        sat_res_t rs;
        stg_next[1] = '0;
        for (int k = 2; k <= STAGES; k++) begin
            stg_next[k] = stg_reg[k-1];
        end

        // stage 1: wave phase and the three products on the raw inputs
        stg_next[1].phase = 32'(freq_reg * s_sim_time);
        stg_next[1].prod0 = prod_t'(cubic_gain_reg) * prod_t'(s_excitation);
        stg_next[1].prod1 = prod_t'(recovery_coupling_reg) * prod_t'(s_recovery);
        stg_next[1].prod2 = prod_t'(recovery_decay_reg) * prod_t'(s_recovery);
        rs = sat32(prod_t'(upper_root_reg) - prod_t'(s_excitation));
        stg_next[1].d2   = rs.val;
        stg_next[1].sat  = rs.ovf;
        stg_next[1].u    = s_excitation;
        stg_next[1].stim = s_stimulus;

        // stage 2: a*u, b*r, gamma*r
        rs = qround(stg_reg[1].prod0);
        stg_next[2].au  = rs.val;
        stg_next[2].sat = stg_next[2].sat | rs.ovf;
        rs = qround(stg_reg[1].prod1);
        stg_next[2].q   = rs.val;
        stg_next[2].sat = stg_next[2].sat | rs.ovf;
        rs = qround(stg_reg[1].prod2);
        stg_next[2].e   = rs.val;
        stg_next[2].sat = stg_next[2].sat | rs.ovf;

        // stage 3: e = u - gamma*r
        rs = sat32(prod_t'(stg_reg[2].u) - prod_t'(stg_reg[2].e));
        stg_next[3].e   = rs.val;
        stg_next[3].sat = stg_next[3].sat | rs.ovf;

        // stage 4: epsilon*e
        stg_next[4].prod2 = prod_t'(recovery_rate_reg) * prod_t'(stg_reg[3].e);

        // stage 5: amplitude times sine, round dr
        stg_next[5].prod0 = prod_t'(amp_reg) * prod_t'(sine_val);
        rs = qround(stg_reg[4].prod2);
        stg_next[5].dr  = rs.val;
        stg_next[5].sat = stg_next[5].sat | rs.ovf;

        // stage 6: beta
        if (slow_wave_mode_reg) begin
            rs = qround(stg_reg[5].prod0);
            stg_next[6].beta = rs.val;
            stg_next[6].sat  = stg_next[6].sat | rs.ovf;
        end else begin
            stg_next[6].beta = amp_reg;
        end

        // stage 7: d1 = u - beta
        rs = sat32(prod_t'(stg_reg[6].u) - prod_t'(stg_reg[6].beta));
        stg_next[7].d1  = rs.val;
        stg_next[7].sat = stg_next[7].sat | rs.ovf;

        // stages 8..11: ((a*u)*d1)*d2
        stg_next[8].prod0 = prod_t'(stg_reg[7].au) * prod_t'(stg_reg[7].d1);
        rs = qround(stg_reg[8].prod0);
        stg_next[9].p   = rs.val;
        stg_next[9].sat = stg_next[9].sat | rs.ovf;
        stg_next[10].prod0 = prod_t'(stg_reg[9].p) * prod_t'(stg_reg[9].d2);
        rs = qround(stg_reg[10].prod0);
        stg_next[11].p   = rs.val;
        stg_next[11].sat = stg_next[11].sat | rs.ovf;

        // output: du = p - q + stim
        rs = sat32(prod_t'(stg_reg[STAGES].p) - prod_t'(stg_reg[STAGES].q)
                   + prod_t'(stg_reg[STAGES].stim));
        m_du_next  = rs.val;
        m_sat_next = stg_reg[STAGES].sat | rs.ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (stage_en[1]) begin
                valid_reg[1] <= s_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (out_en) begin
                m_valid_reg <= valid_reg[STAGES];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= STAGES; k++) begin
            if (stage_en[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
        if (out_en) begin
            m_du_reg  <= m_du_next;
            m_dr_reg  <= stg_reg[STAGES].dr;
            m_sat_reg <= m_sat_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_excitation_rate   = m_du_reg;
    assign m_recovery_rate_out = m_dr_reg;
    assign m_saturated         = m_sat_reg;

    `FND_ASSERT_IMPL(a_empty_out_ready, aclk, aresetn, !m_valid_reg, s_ready, "input blocked with empty output")
    `FND_ASSERT_IMPL(a_out_from_last, aclk, aresetn, $rose(m_valid_reg), $past(valid_reg[STAGES]), "result appeared without a last-stage item")
    `FND_ASSERT_NEXT(a_out_drains, aclk, aresetn, m_valid_reg && m_ready && !valid_reg[STAGES], !m_valid_reg, "result repeated after transfer")

endmodule

### rtl/fnd_sine.sv
// Three-stage quarter-wave sine lookup: phase to step, table address, signed sample.
`timescale 1ns / 1ps

module fnd_sine
    import fnd_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  sine_ctl_t   ctl,
    input  logic [31:0] phase,
    output sine_t       sine
);

    localparam int STEP_W = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);

    localparam logic [63:0]        FOUR_DEPTH = 64'(4 * SINE_TABLE_DEPTH);
    localparam logic [63:0]        DEPTH_U64  = 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0]        HALF_DEPTH = 64'(SINE_TABLE_DEPTH / 2);
    localparam logic [STEP_W-1:0]  Q1_START   = STEP_W'(SINE_TABLE_DEPTH);
    localparam logic [STEP_W-1:0]  Q2_START   = STEP_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [STEP_W-1:0]  Q3_START   = STEP_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [ADDR_W-1:0]  ADDR_TOP   = ADDR_W'(SINE_TABLE_DEPTH);
    localparam logic [63:0]        TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // table entry k: Taylor series of sin in Q30, each term truncated, then Q16
    function automatic logic [ROM_W-1:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (HALF_PI_Q30 * 64'(k) + HALF_DEPTH) / DEPTH_U64;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd8192) >>> 14;
        if (sum > 65536) begin
            sum = 65536;
        end
        return ROM_W'(sum);
    endfunction

    logic [ROM_W-1:0] rom_tbl [SINE_TABLE_DEPTH+1];

    for (genvar gk = 0; gk <= SINE_TABLE_DEPTH; gk++) begin : g_rom
        assign rom_tbl[gk] = sine_entry(gk);
    end

    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              neg_reg, neg_next;
    sine_t             sine_reg, sine_next;

    always_comb begin
        logic [63:0] step_prod;
        step_prod = 64'(phase) * FOUR_DEPTH;
        step_next = step_prod[32 +: STEP_W];
    end

    always_comb begin
        logic [1:0]        quad;
        logic [STEP_W-1:0] off_full;
        logic [ADDR_W-1:0] off;
        if (step_reg >= Q3_START) begin
            quad     = 2'd3;
            off_full = step_reg - Q3_START;
        end else if (step_reg >= Q2_START) begin
            quad     = 2'd2;
            off_full = step_reg - Q2_START;
        end else if (step_reg >= Q1_START) begin
            quad     = 2'd1;
            off_full = step_reg - Q1_START;
        end else begin
            quad     = 2'd0;
            off_full = step_reg;
        end
        off       = off_full[ADDR_W-1:0];
        // odd quadrants run the table backward
        addr_next = quad[0] ? (ADDR_TOP - off) : off;
        neg_next  = quad[1];
    end

    always_comb begin
        sine_t mag;
        mag       = sine_t'({1'b0, rom_tbl[addr_reg]});
        sine_next = neg_reg ? -mag : mag;
    end

    always_ff @(posedge aclk) begin
        if (ctl.step_en) begin
            step_reg <= step_next;
        end
        if (ctl.addr_en) begin
            addr_reg <= addr_next;
            neg_reg  <= neg_next;
        end
        if (ctl.rom_en) begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule
